>>> hw/rtl/sgbc_pkg.sv
// Shared widths, codes, item types and the saturation helper of the
// ghost-cell boundary unit. No dependencies.
`default_nettype none

package sgbc_pkg;

    localparam int DATA_W   = 32;
    localparam int TAG_W    = 16;
    localparam int DIST_W   = 31;
    localparam int REGION_W = 8;
    localparam int IDX_W    = 3;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 2;

    // B*2^17 / d quotient, Robin ratio remainders, fraction quotient bits
    localparam int Q_SHIFT  = 17;
    localparam int QUO_W    = DATA_W + Q_SHIFT;
    localparam int RB_W     = QUO_W + 2;
    localparam int RM_W     = RB_W - 1;
    localparam int FRAC_W   = 32;
    localparam int BETA_W   = 48;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int SAT_W    = 82;

    localparam logic [KIND_W-1:0] KIND_DIRICHLET = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NEUMANN   = 2'd1;

    localparam logic [STATUS_W-1:0] ST_APPLIED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SKIPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    localparam logic ACT_FILL  = 1'b0;
    localparam logic ACT_CLOSE = 1'b1;

    localparam logic [IDX_W-1:0] REG_KIND   = 3'd0;
    localparam logic [IDX_W-1:0] REG_VALUE  = 3'd1;
    localparam logic [IDX_W-1:0] REG_A      = 3'd2;
    localparam logic [IDX_W-1:0] REG_B      = 3'd3;
    localparam logic [IDX_W-1:0] REG_C      = 3'd4;
    localparam logic [IDX_W-1:0] REG_FILTER = 3'd5;
    localparam logic [IDX_W-1:0] REG_SELECT = 3'd6;

    typedef struct packed {
        logic                     act;
        logic [TAG_W-1:0]         tag;
        logic signed [DATA_W-1:0] o;
        logic signed [DATA_W-1:0] p;
        logic [DIST_W-1:0]        d;
        logic                     skip;
    } item_t;

    typedef struct packed {
        item_t                    it;
        logic signed [BETA_W-1:0] nbeta;
        logic                     ovfa;
        logic                     ovfb;
        logic                     nega;
        logic                     negb;
        logic                     invalid;
    } flane_t;

    typedef struct packed {
        item_t                    it;
        logic signed [DATA_W-1:0] alpha;
        logic signed [BETA_W-1:0] beta;
        logic [STATUS_W-1:0]      st;
    } coef_t;

    typedef struct packed {
        logic                     act;
        logic [TAG_W-1:0]         tag;
        logic signed [PROD_W-1:0] pa;
        logic signed [PROD_W-1:0] pd;
        logic signed [56:0]       ph;
        logic signed [57:0]       pl;
        logic signed [BETA_W-1:0] beta;
        logic [STATUS_W-1:0]      st;
    } prod_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        logic signed [DATA_W-1:0] r;
        hi = $signed({{(SAT_W-DATA_W){1'b0}}, 32'h7FFF_FFFF});
        lo = $signed({{(SAT_W-DATA_W){1'b1}}, 32'h8000_0000});
        if (x > hi)
            r = 32'sh7FFF_FFFF;
        else if (x < lo)
            r = 32'sh8000_0000;
        else
            r = x[DATA_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/scalar_ghost_bc_fill_close.sv
// Top level of the scalar ghost-cell boundary unit (fill and close).
// Uses sgbc_pkg and two kinds of sgbc_div_pipe instances.
//
//   channel   dir  handshake           payload
//   in        in   in_valid/in_ready   action face_id owner_value normal_distance
//                                      pending_coeff owner_region
//   out       out  out_valid/out_ready face_tag action_echo ghost_value
//                                      diag_increment rhs_increment status
//   cfg       in   cfg_valid/cfg_ready cfg_index cfg_data
//
// One face per cycle while the output register is not stalled; each result passes
// through the entry register, the 49-stage B*2^17/d divider, the 32-stage Robin
// ratio dividers, and the combine, multiply and output registers.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears all valid bits and configuration registers; cfg_ready is always high.
`default_nettype none

module scalar_ghost_bc_fill_close (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           action,
    input  wire logic [sgbc_pkg::TAG_W-1:0]     face_id,
    input  wire logic signed [sgbc_pkg::DATA_W-1:0] owner_value,
    input  wire logic [sgbc_pkg::DIST_W-1:0]    normal_distance,
    input  wire logic signed [sgbc_pkg::DATA_W-1:0] pending_coeff,
    input  wire logic [sgbc_pkg::REGION_W-1:0]  owner_region,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [sgbc_pkg::TAG_W-1:0]          face_tag,
    output logic                                action_echo,
    output logic signed [sgbc_pkg::DATA_W-1:0]  ghost_value,
    output logic signed [sgbc_pkg::DATA_W-1:0]  diag_increment,
    output logic signed [sgbc_pkg::DATA_W-1:0]  rhs_increment,
    output logic [sgbc_pkg::STATUS_W-1:0]       status,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sgbc_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [sgbc_pkg::DATA_W-1:0]    cfg_data
);

    import sgbc_pkg::*;

    // configuration
    logic [KIND_W-1:0]   kind_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [DATA_W-1:0]   a_reg;
    logic [DATA_W-1:0]   b_reg;
    logic [DATA_W-1:0]   c_reg;
    logic                filt_reg;
    logic [REGION_W-1:0] sel_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            kind_reg  <= '0;
            value_reg <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            c_reg     <= '0;
            filt_reg  <= 1'b0;
            sel_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KIND:   kind_reg  <= cfg_data[KIND_W-1:0];
                REG_VALUE:  value_reg <= cfg_data;
                REG_A:      a_reg     <= cfg_data;
                REG_B:      b_reg     <= cfg_data;
                REG_C:      c_reg     <= cfg_data;
                REG_FILTER: filt_reg  <= cfg_data[0];
                REG_SELECT: sel_reg   <= cfg_data[REGION_W-1:0];
                default:    ;
            endcase
        end
    end

    logic en;
    logic out_vld_reg;

    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    // entry stage
    logic  s0_vld_reg;
    item_t s0_reg;
    item_t s0_next;

    always_comb begin
        s0_next.act  = action;
        s0_next.tag  = face_id;
        s0_next.o    = owner_value;
        s0_next.p    = pending_coeff;
        s0_next.d    = (normal_distance == '0) ? DIST_W'(1) : normal_distance;
        s0_next.skip = filt_reg && (owner_region != sel_reg);
    end

    // q = trunc(B * 2^17 / d), magnitude first
    logic [DATA_W-1:0] babs;
    logic [QUO_W-1:0]  quo_q;

    assign babs = b_reg[DATA_W-1] ? (~b_reg + DATA_W'(1)) : b_reg;

    sgbc_div_pipe #(
        .DVW (DIST_W),
        .NQ  (QUO_W)
    ) u_qdiv (
        .clk     (clk),
        .en      (en),
        .rem_in  ('0),
        .bits_in ({babs, {Q_SHIFT{1'b0}}}),
        .divisor (s0_reg.d),
        .quo     (quo_q)
    );

    logic [QUO_W-1:0] vq_reg;
    item_t            pq_reg [QUO_W];

    // stage A: Robin numerator and denominator, Neumann beta
    logic                     sa_vld_reg;
    item_t                    sa_it_reg;
    logic signed [RB_W-1:0]   den_reg;
    logic signed [RB_W-1:0]   num_reg;
    logic signed [BETA_W-1:0] nbeta_reg;

    logic signed [RB_W-1:0]   qmag;
    logic signed [RB_W-1:0]   qsig;
    logic signed [RB_W-1:0]   aext;
    logic signed [RB_W-1:0]   den_next;
    logic signed [RB_W-1:0]   num_next;
    logic signed [PROD_W-1:0] nprod;

    assign qmag     = $signed({2'b00, quo_q});
    assign qsig     = b_reg[DATA_W-1] ? -qmag : qmag;
    assign aext     = $signed({{(RB_W-DATA_W){a_reg[DATA_W-1]}}, a_reg});
    assign den_next = qsig + aext;
    assign num_next = qsig - aext;
    assign nprod    = $signed(value_reg) * $signed({1'b0, pq_reg[QUO_W-1].d});

    // Robin ratios: magnitudes, overflow and signs
    logic [RM_W-1:0]   ud;
    logic [RM_W-1:0]   una;
    logic [RM_W-1:0]   unb;
    logic [DATA_W:0]   c2abs;
    logic [DATA_W+1:0] c2;
    flane_t            f0_next;
    logic [FRAC_W-1:0] quo_a;
    logic [FRAC_W-1:0] quo_b;

    assign ud    = den_reg[RB_W-1] ? RM_W'(-den_reg) : RM_W'(den_reg);
    assign una   = num_reg[RB_W-1] ? RM_W'(-num_reg) : RM_W'(num_reg);
    assign c2    = {c_reg[DATA_W-1], c_reg, 1'b0};
    assign c2abs = c2[DATA_W+1] ? (DATA_W+1)'(~c2 + 1'b1) : c2[DATA_W:0];
    assign unb   = RM_W'(c2abs);

    always_comb begin
        f0_next.it      = sa_it_reg;
        f0_next.nbeta   = nbeta_reg;
        f0_next.ovfa    = {16'b0, una[RM_W-1:16]} >= ud;
        f0_next.ovfb    = {16'b0, unb[RM_W-1:16]} >= ud;
        f0_next.nega    = num_reg[RB_W-1] ^ den_reg[RB_W-1];
        f0_next.negb    = c_reg[DATA_W-1] ^ den_reg[RB_W-1];
        f0_next.invalid = (den_reg == '0);
    end

    sgbc_div_pipe #(
        .DVW (RM_W),
        .NQ  (FRAC_W)
    ) u_adiv (
        .clk     (clk),
        .en      (en),
        .rem_in  ({16'b0, una[RM_W-1:16]}),
        .bits_in ({una[15:0], 16'b0}),
        .divisor (ud),
        .quo     (quo_a)
    );

    sgbc_div_pipe #(
        .DVW (RM_W),
        .NQ  (FRAC_W)
    ) u_bdiv (
        .clk     (clk),
        .en      (en),
        .rem_in  ({16'b0, unb[RM_W-1:16]}),
        .bits_in ({unb[15:0], 16'b0}),
        .divisor (ud),
        .quo     (quo_b)
    );

    logic [FRAC_W-1:0] vf_reg;
    flane_t            pf_reg [FRAC_W];

    // stage C: pick alpha and beta, decide status
    logic  sc_vld_reg;
    coef_t sc_reg;
    coef_t sc_next;

    flane_t                   fe;
    logic [DATA_W:0]          maga;
    logic [DATA_W:0]          magb;
    logic signed [DATA_W+1:0] sa;
    logic signed [DATA_W+1:0] sb;
    logic signed [DATA_W-1:0] ra;
    logic signed [DATA_W-1:0] rb;

    assign fe   = pf_reg[FRAC_W-1];
    assign maga = fe.ovfa ? {1'b1, {DATA_W{1'b0}}} : {1'b0, quo_a};
    assign magb = fe.ovfb ? {1'b1, {DATA_W{1'b0}}} : {1'b0, quo_b};
    assign sa   = fe.nega ? -$signed({1'b0, maga}) : $signed({1'b0, maga});
    assign sb   = fe.negb ? -$signed({1'b0, magb}) : $signed({1'b0, magb});
    assign ra   = sat32({{(SAT_W-DATA_W-2){sa[DATA_W+1]}}, sa});
    assign rb   = sat32({{(SAT_W-DATA_W-2){sb[DATA_W+1]}}, sb});

    always_comb begin
        sc_next.it = fe.it;
        case (kind_reg)
            KIND_DIRICHLET:
            begin
                sc_next.alpha = 32'shFFFF_0000;
                sc_next.beta  = $signed({{(BETA_W-DATA_W-1){value_reg[DATA_W-1]}},
                                         value_reg, 1'b0});
            end
            KIND_NEUMANN:
            begin
                sc_next.alpha = 32'sh0001_0000;
                sc_next.beta  = fe.nbeta;
            end
            default:
            begin
                sc_next.alpha = ra;
                sc_next.beta  = $signed({{(BETA_W-DATA_W){rb[DATA_W-1]}}, rb});
            end
        endcase
        if (fe.it.skip)
            sc_next.st = ST_SKIPPED;
        else if (kind_reg != KIND_DIRICHLET && kind_reg != KIND_NEUMANN && fe.invalid)
            sc_next.st = ST_INVALID;
        else
            sc_next.st = ST_APPLIED;
    end

    // stage D: products, rhs split into two partial products on beta
    logic  sd_vld_reg;
    prod_t sd_reg;
    prod_t sd_next;

    logic signed [DATA_W:0] np;

    assign np = -$signed({sc_reg.it.p[DATA_W-1], sc_reg.it.p});

    always_comb begin
        sd_next.act  = sc_reg.it.act;
        sd_next.tag  = sc_reg.it.tag;
        sd_next.pa   = sc_reg.alpha * sc_reg.it.o;
        sd_next.pd   = sc_reg.it.p * sc_reg.alpha;
        sd_next.ph   = np * $signed(sc_reg.beta[BETA_W-1:24]);
        sd_next.pl   = np * $signed({1'b0, sc_reg.beta[23:0]});
        sd_next.beta = sc_reg.beta;
        sd_next.st   = sc_reg.st;
    end

    // output stage
    logic [TAG_W-1:0]         tag_reg;
    logic                     act_reg;
    logic signed [DATA_W-1:0] ghost_reg;
    logic signed [DATA_W-1:0] diag_reg;
    logic signed [DATA_W-1:0] rhs_reg;
    logic [STATUS_W-1:0]      st_reg;

    logic signed [SAT_W-1:0]  gsum;
    logic signed [SAT_W-1:0]  dsum;
    logic signed [SAT_W-1:0]  rfull;
    logic signed [SAT_W-1:0]  rsum;
    logic                     apply;
    logic signed [DATA_W-1:0] ghost_next;
    logic signed [DATA_W-1:0] diag_next;
    logic signed [DATA_W-1:0] rhs_next;

    assign gsum  = $signed({{(SAT_W-48){sd_reg.pa[PROD_W-1]}}, sd_reg.pa[PROD_W-1:16]})
                 + $signed({{(SAT_W-BETA_W){sd_reg.beta[BETA_W-1]}}, sd_reg.beta});
    assign dsum  = $signed({{(SAT_W-48){sd_reg.pd[PROD_W-1]}}, sd_reg.pd[PROD_W-1:16]});
    assign rfull = ($signed({{(SAT_W-57){sd_reg.ph[56]}}, sd_reg.ph}) <<< 24)
                 + $signed({{(SAT_W-58){sd_reg.pl[57]}}, sd_reg.pl});
    assign rsum  = rfull >>> 16;
    assign apply = (sd_reg.st == ST_APPLIED);

    assign ghost_next = (apply && sd_reg.act == ACT_FILL)  ? sat32(gsum) : '0;
    assign diag_next  = (apply && sd_reg.act == ACT_CLOSE) ? sat32(dsum) : '0;
    assign rhs_next   = (apply && sd_reg.act == ACT_CLOSE) ? sat32(rsum) : '0;

    // valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            vq_reg      <= '0;
            sa_vld_reg  <= 1'b0;
            vf_reg      <= '0;
            sc_vld_reg  <= 1'b0;
            sd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg  <= in_valid;
            vq_reg      <= {vq_reg[QUO_W-2:0], s0_vld_reg};
            sa_vld_reg  <= vq_reg[QUO_W-1];
            vf_reg      <= {vf_reg[FRAC_W-2:0], sa_vld_reg};
            sc_vld_reg  <= vf_reg[FRAC_W-1];
            sd_vld_reg  <= sc_vld_reg;
            out_vld_reg <= sd_vld_reg;
        end
    end

    // payload, advance with the valid bits
    always_ff @(posedge clk) begin
        if (en)
        begin
            s0_reg    <= s0_next;
            pq_reg[0] <= s0_reg;
            for (int k = 1; k < QUO_W; k++)
                pq_reg[k] <= pq_reg[k-1];
            sa_it_reg <= pq_reg[QUO_W-1];
            den_reg   <= den_next;
            num_reg   <= num_next;
            nbeta_reg <= nprod[PROD_W-1:16];
            pf_reg[0] <= f0_next;
            for (int k = 1; k < FRAC_W; k++)
                pf_reg[k] <= pf_reg[k-1];
            sc_reg    <= sc_next;
            sd_reg    <= sd_next;
            tag_reg   <= sd_reg.tag;
            act_reg   <= sd_reg.act;
            ghost_reg <= ghost_next;
            diag_reg  <= diag_next;
            rhs_reg   <= rhs_next;
            st_reg    <= sd_reg.st;
        end
    end

    assign out_valid      = out_vld_reg;
    assign face_tag       = tag_reg;
    assign action_echo    = act_reg;
    assign ghost_value    = ghost_reg;
    assign diag_increment = diag_reg;
    assign rhs_increment  = rhs_reg;
    assign status         = st_reg;

    a_not_applied_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_APPLIED
        |-> ghost_value == '0 && diag_increment == '0 && rhs_increment == '0)
        else $error("non-applied result carries a value");

    a_fill_no_close: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action_echo == ACT_FILL
        |-> diag_increment == '0 && rhs_increment == '0)
        else $error("fill result carries matrix increments");

    a_close_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action_echo == ACT_CLOSE |-> ghost_value == '0)
        else $error("close result carries a ghost value");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(vq_reg) && $stable(vf_reg))
        else $error("pipeline moved during a stall");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input held off without a blocked output");

endmodule

`default_nettype wire

>>> hw/rtl/sgbc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Divisor travels with each item; no package dependency.
`default_nettype none

module sgbc_div_pipe #(
    parameter int DVW = 31,
    parameter int NQ  = 49
) (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [DVW-1:0] rem_in,
    input  wire logic [NQ-1:0]  bits_in,
    input  wire logic [DVW-1:0] divisor,
    output logic      [NQ-1:0]  quo
);

    logic [DVW-1:0] rem_reg  [NQ];
    logic [NQ-1:0]  bits_reg [NQ];
    logic [NQ-1:0]  quo_reg  [NQ];
    logic [DVW-1:0] dv_reg   [NQ];

    for (genvar k = 0; k < NQ; k++) begin : g_stage
        logic [DVW-1:0] rp;
        logic [NQ-1:0]  bp;
        logic [NQ-1:0]  qp;
        logic [DVW-1:0] dp;
        logic [DVW:0]   t;
        logic [DVW:0]   diff;
        logic           ge;
        logic [DVW-1:0] rem_next;

        if (k == 0) begin : g_first
            assign rp = rem_in;
            assign bp = bits_in;
            assign qp = '0;
            assign dp = divisor;
        end else begin : g_rest
            assign rp = rem_reg[k-1];
            assign bp = bits_reg[k-1];
            assign qp = quo_reg[k-1];
            assign dp = dv_reg[k-1];
        end

        // shift in the next dividend bit, subtract when it fits
        assign t        = {rp, bp[NQ-1]};
        assign diff     = t - {1'b0, dp};
        assign ge       = (t >= {1'b0, dp});
        assign rem_next = ge ? diff[DVW-1:0] : t[DVW-1:0];

        always_ff @(posedge clk) begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                bits_reg[k] <= {bp[NQ-2:0], 1'b0};
                quo_reg[k]  <= {qp[NQ-2:0], ge};
                dv_reg[k]   <= dp;
            end
        end
    end

    assign quo = quo_reg[NQ-1];

endmodule

`default_nettype wire

>>> sim/tb_scalar_ghost_bc_fill_close.sv
// Self-checking testbench for scalar_ghost_bc_fill_close: random and directed faces
// against a Q16.16 boundary-condition predictor. Depends on sgbc_pkg and the RTL top.
`default_nettype none

module tb_scalar_ghost_bc_fill_close;
    import sgbc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_ROBIN  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 140;
    localparam int DRAIN_WAIT  = 100;
    localparam int IDLE_LIMIT  = 5000;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        logic [TAG_W-1:0]         tag;
        logic                     act;
        logic signed [DATA_W-1:0] ghost;
        logic signed [DATA_W-1:0] diag;
        logic signed [DATA_W-1:0] rhs;
        logic [STATUS_W-1:0]      st;
    } face_res_t;

    class bc_scoreboard;
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value, coef_a, coef_b, coef_c;
        logic                     filt;
        logic [REGION_W-1:0]      sel;
        face_res_t                pending_q[$];
        int                       errors;
        int                       checked;
        int                       n_skip, n_invalid, n_fill, n_close;

        function new();
            kind = 0; value = 0; coef_a = 0; coef_b = 0; coef_c = 0; filt = 0; sel = 0;
            errors = 0; checked = 0; n_skip = 0; n_invalid = 0; n_fill = 0; n_close = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_KIND:   kind   = data[KIND_W-1:0];
                REG_VALUE:  value  = data;
                REG_A:      coef_a = data;
                REG_B:      coef_b = data;
                REG_C:      coef_c = data;
                REG_FILTER: filt   = data[0];
                REG_SELECT: sel    = data[REGION_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clip(logic signed [127:0] x);
            if (x > 128'sd2147483647)
                return 64'sd2147483647;
            if (x < -128'sd2147483648)
                return -64'sd2147483648;
            return longint'(x);
        endfunction

        // floor(x*y / 2^16), saturated
        function longint scaled(longint x, longint y);
            logic signed [127:0] tx, ty;
            tx = x;
            ty = y;
            return clip((tx * ty) >>> 16);
        endfunction

        // trunc(n*2^16 / d), saturated
        function longint ratio(longint n, longint d);
            logic [127:0]        un, ud, m;
            logic signed [127:0] s;
            un = (n < 0) ? -n : n;
            ud = (d < 0) ? -d : d;
            m = (un << 16) / ud;
            s = ((n < 0) != (d < 0)) ? -$signed(m) : $signed(m);
            return clip(s);
        endfunction

        function void note_face(logic act, logic [TAG_W-1:0] tag,
                                logic signed [DATA_W-1:0] o, logic [DIST_W-1:0] d,
                                logic signed [DATA_W-1:0] p, logic [REGION_W-1:0] rgn);
            longint    dd, q, den, alpha, beta;
            face_res_t r;
            dd = (d == 0) ? 64'd1 : longint'(d);
            alpha = 0;
            beta = 0;
            r.tag = tag; r.act = act; r.ghost = 0; r.diag = 0; r.rhs = 0; r.st = ST_APPLIED;
            if (filt && rgn != sel) begin
                r.st = ST_SKIPPED;
            end else begin
                if (kind == KIND_DIRICHLET) begin
                    alpha = -65536;
                    beta = 2 * longint'(value);
                end else if (kind == KIND_NEUMANN) begin
                    alpha = 65536;
                    beta = (longint'(value) * dd) >>> 16;
                end else begin
                    q = (longint'(coef_b) * 131072) / dd;
                    den = longint'(coef_a) + q;
                    if (den == 0) begin
                        r.st = ST_INVALID;
                    end else begin
                        alpha = ratio(q - longint'(coef_a), den);
                        beta = ratio(2 * longint'(coef_c), den);
                    end
                end
                if (r.st == ST_APPLIED) begin
                    if (act == ACT_FILL)
                        r.ghost = clip(((alpha * longint'(o)) >>> 16) + beta);
                    else begin
                        r.diag = scaled(longint'(p), alpha);
                        r.rhs = scaled(-longint'(p), beta);
                    end
                end
            end
            if (r.st == ST_SKIPPED) n_skip++;
            else if (r.st == ST_INVALID) n_invalid++;
            else if (act == ACT_FILL) n_fill++;
            else n_close++;
            pending_q.push_back(r);
        endfunction

        function void check_face(face_res_t got);
            face_res_t want;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: tag %h status %0d", got.tag, got.st);
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (got.tag !== want.tag || got.act !== want.act || got.ghost !== want.ghost ||
                got.diag !== want.diag || got.rhs !== want.rhs || got.st !== want.st) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp: tag %h act %b ghost %h diag %h rhs %h st %0d",
                             want.tag, want.act, want.ghost, want.diag, want.rhs, want.st);
                    $display("         got: tag %h act %b ghost %h diag %h rhs %h st %0d",
                             got.tag, got.act, got.ghost, got.diag, got.rhs, got.st);
                end
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic in_valid, in_ready, action, out_valid, out_ready, action_echo;
    logic [TAG_W-1:0] face_id, face_tag;
    logic signed [DATA_W-1:0] owner_value, pending_coeff, ghost_value;
    logic signed [DATA_W-1:0] diag_increment, rhs_increment;
    logic [DIST_W-1:0] normal_distance;
    logic [REGION_W-1:0] owner_region;
    logic [STATUS_W-1:0] status;
    logic cfg_valid, cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;

    bc_scoreboard sb = new();
    int  send_idle_pct, recv_idle_pct;
    int  hold_left;
    bit  hold_req;
    int  quiet_cycles;

    scalar_ghost_bc_fill_close dut (.*);

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // receiver: random backpressure plus an occasional long hold-off
    always @(posedge clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        face_res_t got;
        if (rst_n && out_valid && out_ready) begin
            got.tag = face_tag; got.act = action_echo; got.ghost = ghost_value;
            got.diag = diag_increment; got.rhs = rhs_increment; got.st = status;
            sb.check_face(got);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("scalar_ghost_bc_fill_close verification failed");
            $finish;
        end
    end

    task automatic write_cfg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic send_face(logic act, logic [TAG_W-1:0] tag, logic signed [DATA_W-1:0] o,
                             logic [DIST_W-1:0] d, logic signed [DATA_W-1:0] p,
                             logic [REGION_W-1:0] rgn);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        action          <= act;
        face_id         <= tag;
        owner_value     <= o;
        normal_distance <= d;
        pending_coeff   <= p;
        owner_region    <= rgn;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_face(act, tag, o, d, p, rgn);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [DIST_W-1:0] pick_dist();
        case ($urandom_range(5))
            0: return '0;
            1: return 31'h7FFF_FFFF;
            2: return DIST_W'($urandom_range(31'h0004_0000, 1));
            default: return DIST_W'($urandom());
        endcase
    endfunction

    task automatic random_face();
        logic [REGION_W-1:0] rgn;
        rgn = ($urandom_range(2) == 0) ? REGION_W'($urandom()) : sb.sel;
        send_face(1'($urandom()), TAG_W'($urandom()), pick_word(), pick_dist(), pick_word(),
                  rgn);
    endtask

    task automatic random_config(int ph);
        logic [DATA_W-1:0] a, b;
        a = pick_word();
        b = pick_word();
        write_cfg(REG_KIND, DATA_W'(ph % 4));
        write_cfg(REG_VALUE, pick_word());
        // even phases pick A = -2B, so each Robin setting makes the denominator vanish at some distances
        if (ph % 2 == 0) begin
            b = $urandom_range(16) << 12;
            a = 32'h0 - b * 2;
        end
        write_cfg(REG_A, a);
        write_cfg(REG_B, b);
        write_cfg(REG_C, pick_word());
        write_cfg(REG_FILTER, DATA_W'(ph % 3 == 1));
        write_cfg(REG_SELECT, (ph == 4) ? 32'h0000_00FF : $urandom());
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0; action = 1'b0; face_id = '0; owner_value = '0;
        normal_distance = '0; pending_coeff = '0; owner_region = '0;
        out_ready = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        hold_left = 0; hold_req = 1'b0; quiet_cycles = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: each condition kind at field extremes, zero distance, skip, bad Robin
        send_face(ACT_FILL, 16'h0000, 32'h7FFF_FFFF, '0, 32'h8000_0000, 8'h00);
        in_valid <= 1'b0;
        drain();
        write_cfg(REG_VALUE, 32'h7FFF_FFFF);
        send_face(ACT_FILL, 16'hFFFF, 32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF);
        send_face(ACT_CLOSE, 16'h1234, 32'h0001_0000, 31'h0001_0000, 32'h8000_0000, 8'h55);
        in_valid <= 1'b0;
        drain();
        write_cfg(REG_KIND, DATA_W'(KIND_NEUMANN));
        write_cfg(REG_VALUE, 32'h8000_0000);
        send_face(ACT_FILL, 16'hFFFE, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h0, 8'hAA);
        send_face(ACT_CLOSE, 16'h0001, 32'h0, 31'h7FFF_FFFF, 32'h8000_0000, 8'h01);
        send_face(ACT_CLOSE, 16'h0002, 32'h0, '0, 32'h7FFF_FFFF, 8'h02);
        in_valid <= 1'b0;
        drain();
        write_cfg(REG_KIND, DATA_W'(KIND_ROBIN));
        write_cfg(REG_A, 32'h0);
        write_cfg(REG_B, 32'h0);
        write_cfg(REG_C, 32'h7FFF_FFFF);
        send_face(ACT_FILL, 16'h0003, 32'h0001_0000, 31'h0001_0000, 32'h0, 8'h00);
        send_face(ACT_CLOSE, 16'h0004, 32'h0001_0000, '0, 32'h0001_0000, 8'h00);
        in_valid <= 1'b0;
        drain();
        write_cfg(REG_A, 32'h0001_0000);
        write_cfg(REG_B, 32'h8000_0000);
        send_face(ACT_FILL, 16'h0005, 32'h8000_0000, '0, 32'h0, 8'h00);
        send_face(ACT_CLOSE, 16'h0006, 32'h0, 31'h0000_0001, 32'h8000_0000, 8'h00);
        send_face(ACT_CLOSE, 16'h0007, 32'h0, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h00);
        in_valid <= 1'b0;
        drain();
        write_cfg(REG_KIND, DATA_W'(KIND_SPARE));
        write_cfg(REG_FILTER, 32'h0000_0001);
        write_cfg(REG_SELECT, 32'h0000_005A);
        send_face(ACT_FILL, 16'h0008, 32'h0001_0000, 31'h0002_0000, 32'h0, 8'h5A);
        send_face(ACT_CLOSE, 16'h0009, 32'h0001_0000, 31'h0002_0000, 32'h1, 8'hA5);
        send_face(ACT_FILL, 16'h000A, 32'h0, 31'h0002_0000, 32'h0, 8'h00);
        in_valid <= 1'b0;
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph * 3 / N_PHASES)
                0: begin send_idle_pct = 30; recv_idle_pct = 65; end
                1: begin send_idle_pct = 65; recv_idle_pct = 30; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            random_config(ph);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == 40 && (ph == 2 || ph == 6))
                    hold_req = 1'b1;
                if (i == 90 && ph == 3) begin
                    in_valid <= 1'b0;
                    while (sb.pending_q.size() != 0)
                        @(posedge clk);
                end
                random_face();
            end
            in_valid <= 1'b0;
            drain();
        end

        $display("faces checked %0d: fill %0d, close %0d, region skip %0d, bad Robin %0d",
                 sb.checked, sb.n_fill, sb.n_close, sb.n_skip, sb.n_invalid);
        $display("covered all four kind codes, filter on and off, stalls on both sides");
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("scalar_ghost_bc_fill_close verification clean");
        else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending_q.size());
            $display("scalar_ghost_bc_fill_close verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
